// ----- rtl/cht_pkg.sv -----
// Package for the chained hash table: payload structs, codes and sizes.
// Used by chained_hash_table; depends on nothing.
`default_nettype none
package cht_pkg;
  localparam int unsigned DefEntries    = 256;
  localparam int unsigned DefMaxBuckets = 256;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_FIND   = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_FIRST  = 3'd3,
    MODE_NEXT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_HDL = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] data_word;
    logic [7:0]  handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_handle;
    logic [31:0] entry_key;
    logic [31:0] entry_data;
    logic [8:0]  item_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CMP,
    S_RM_RD,
    S_RM_PREV,
    S_RM_NEXT,
    S_RM_OPREV,
    S_RM_ONEXT,
    S_ADD_RD,
    S_ADD_LINK,
    S_FETCH,
    S_FETCH_WAIT,
    S_RESP
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/cht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/chained_hash_table.sv -----
// Chained hash table top level: sequencer over entry, link and bucket RAMs.
// Depends on cht_pkg and cht_ram.
//
//   Channel | Signals                      | Payload
//   req     | req_valid, req_ready         | req_t (mode, key, data_word, handle)
//   rsp     | rsp_valid, rsp_ready         | rsp_t (status, handle, key, data, count)
//   cfg     | cfg_valid, cfg_ready         | bucket_count_log2 (4 bits)
//
// A request walks a sequence of states from acceptance until the block is
// ready again; a find visits the entries of its bucket chain one by one. The
// single read port of each RAM sets the pace, one dependent read per step.
// After reset a clearing pass empties the bucket table; no request is taken
// meanwhile. Only one request is in flight, and the block holds its result
// until rsp_ready is high.
`default_nettype none
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned Entries    = DefEntries,
  parameter int unsigned MaxBuckets = DefMaxBuckets
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);
  localparam int unsigned EW = $clog2(Entries);
  localparam int unsigned BW = $clog2(MaxBuckets);
  localparam int unsigned CW = EW + 1;
  localparam int unsigned LW = 2 * CW;
  localparam int unsigned MaxLog2 = BW;
  localparam logic [CW-1:0] Nil = CW'(Entries);

  state_t state, state_next;
  logic [3:0] bucket_log2;
  req_t cur;
  logic [CW-1:0] count;
  logic [EW-1:0] free_head;
  logic lap;
  logic [EW-1:0] alloc;
  logic [EW-1:0] ent;
  logic [CW-1:0] nx, pv, onx, opv;
  logic [BW-1:0] bkt;
  logic [CW-1:0] oh, ot;
  logic [BW:0] clr;
  logic [1:0] rs;
  logic [CW-1:0] re;
  logic [Entries-1:0] valid;
  logic key_hit;

  logic kwe; logic [EW-1:0] kwa, kra; logic [63:0] kwd, krd;
  logic cwe; logic [EW-1:0] cwa, cra; logic [LW+BW-1:0] cwd, crd;
  logic owe; logic [EW-1:0] owa, ora; logic [LW-1:0] owd, ord_q;
  logic bwe; logic [BW-1:0] bwa, bra; logic [LW-1:0] bwd, brd;
  logic fwe; logic [EW-1:0] fwa, fra; logic [EW-1:0] fwd, frd;

  cht_ram #(.Width(64), .Depth(Entries)) u_kv (
    .clk(clk), .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd));
  cht_ram #(.Width(LW + BW), .Depth(Entries)) u_chain (
    .clk(clk), .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd));
  cht_ram #(.Width(LW), .Depth(Entries)) u_order (
    .clk(clk), .we(owe), .waddr(owa), .wdata(owd), .raddr(ora), .rdata(ord_q));
  cht_ram #(.Width(LW), .Depth(MaxBuckets)) u_bucket (
    .clk(clk), .we(bwe), .waddr(bwa), .wdata(bwd), .raddr(bra), .rdata(brd));
  cht_ram #(.Width(EW), .Depth(Entries)) u_free (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));

  function automatic logic [BW-1:0] bucket_of(logic [31:0] k, logic [3:0] s);
    logic [3:0] e;
    logic [BW-1:0] m;
    e = (s < 4'd4) ? 4'd4 : s;
    if (e > 4'(MaxLog2)) e = 4'(MaxLog2);
    m = BW'((32'd1 << e) - 32'd1);
    return k[BW-1:0] & m;
  endfunction

  logic [CW-1:0] c_nx, c_pv, o_nx, o_pv, b_hd, b_tl;
  logic [BW-1:0] c_bk;
  assign c_nx = crd[LW+BW-1 -: CW];
  assign c_pv = crd[CW+BW-1 -: CW];
  assign c_bk = crd[BW-1:0];
  assign o_nx = ord_q[LW-1 -: CW];
  assign o_pv = ord_q[CW-1:0];
  assign b_hd = brd[LW-1 -: CW];
  assign b_tl = brd[CW-1:0];
  assign key_hit = (krd[63:32] == cur.key);

  // Until the free list has been walked once, its slots are taken as holding their own index.
  assign alloc = lap ? frd : free_head;

  logic hvalid;
  assign hvalid = (32'(cur.handle) < Entries) && valid[cur.handle[EW-1:0]];

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE) && clr[BW];
  assign rsp_valid = (state == S_RESP);
  always_comb begin
    rsp = '0;
    rsp.status = rs;
    rsp.item_count = 9'(count);
    if (rs == ST_OK) begin
      rsp.entry_handle = 8'(re);
      rsp.entry_key = krd[63:32];
      rsp.entry_data = krd[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid && req_ready) state_next = S_DECODE;
      S_DECODE: begin
        case (cur.mode)
          MODE_ADD:    state_next = (count >= CW'(Entries)) ? S_RESP : S_ADD_RD;
          MODE_FIND:   state_next = S_FIND_RD;
          MODE_REMOVE: state_next = hvalid ? S_RM_RD : S_RESP;
          MODE_FIRST:  state_next = (oh == Nil) ? S_RESP : S_FETCH;
          MODE_NEXT:   state_next = hvalid ? S_RM_RD : S_RESP;
          default:     state_next = S_RESP;
        endcase
      end
      S_FIND_RD:  state_next = (b_hd == Nil) ? S_RESP : S_FIND_CMP;
      S_FIND_CMP: state_next = (key_hit || c_nx == Nil) ? S_RESP : S_FIND_CMP;
      S_RM_RD: begin
        if (cur.mode == MODE_NEXT) state_next = (o_nx == Nil) ? S_RESP : S_FETCH;
        else state_next = S_RM_PREV;
      end
      S_RM_PREV:  state_next = S_RM_NEXT;
      S_RM_NEXT:  state_next = S_RM_OPREV;
      S_RM_OPREV: state_next = S_RM_ONEXT;
      S_RM_ONEXT: state_next = S_FETCH;
      S_ADD_RD:   state_next = S_ADD_LINK;
      S_ADD_LINK: state_next = S_FETCH;
      S_FETCH:    state_next = S_FETCH_WAIT;
      S_FETCH_WAIT: state_next = S_RESP;
      S_RESP:     if (rsp_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM port control. Reads are issued in the state before the one that uses their data.
  always_comb begin
    kwe = 1'b0; kwa = ent; kwd = {cur.key, cur.data_word}; kra = ent;
    cwe = 1'b0; cwa = ent; cwd = '0; cra = ent;
    owe = 1'b0; owa = ent; owd = '0; ora = cur.handle[EW-1:0];
    bwe = 1'b0; bwa = bkt; bwd = '0; bra = bkt;
    fwe = 1'b0; fwa = EW'(32'(free_head) + Entries - 32'(count));
    fwd = cur.handle[EW-1:0]; fra = free_head;
    if (!clr[BW]) begin
      bwe = 1'b1; bwa = clr[BW-1:0]; bwd = {Nil, Nil};
    end
    unique case (state)
      S_DECODE: begin
        bra = bucket_of(cur.key, bucket_log2);
        cra = cur.handle[EW-1:0];
      end
      S_FIND_RD: begin
        cra = b_hd[EW-1:0]; kra = b_hd[EW-1:0];
      end
      S_FIND_CMP: begin
        cra = c_nx[EW-1:0]; kra = c_nx[EW-1:0];
        if (key_hit) kra = ent;
      end
      S_RM_RD: begin
        bra = c_bk;
        cra = c_pv[EW-1:0];
      end
      S_RM_PREV: begin
        if (pv == Nil) begin
          bwe = 1'b1; bwd = {nx, b_tl};
        end else begin
          cwe = 1'b1; cwa = pv[EW-1:0]; cwd = {nx, c_pv, bkt};
        end
        cra = nx[EW-1:0];
      end
      S_RM_NEXT: begin
        if (nx == Nil) begin
          bwe = 1'b1;
          bwd = (pv == Nil) ? {Nil, Nil} : {b_hd, pv};
        end else begin
          cwe = 1'b1; cwa = nx[EW-1:0]; cwd = {c_nx, pv, bkt};
        end
        ora = opv[EW-1:0];
      end
      S_RM_OPREV: begin
        if (opv != Nil) begin
          owe = 1'b1; owa = opv[EW-1:0]; owd = {onx, o_pv};
        end
        ora = onx[EW-1:0];
      end
      S_RM_ONEXT: begin
        if (onx != Nil) begin
          owe = 1'b1; owa = onx[EW-1:0]; owd = {o_nx, opv};
        end
        fwe = 1'b1;
      end
      S_ADD_RD: begin
        kwe = 1'b1; kwa = alloc; cra = b_tl[EW-1:0];
        cwe = 1'b1; cwa = alloc; cwd = {Nil, b_tl, bkt};
        owe = 1'b1; owa = alloc; owd = {Nil, ot};
        ora = ot[EW-1:0];
      end
      S_ADD_LINK: begin
        bwe = 1'b1;
        bwd = (b_tl == Nil) ? {CW'(ent), CW'(ent)} : {b_hd, CW'(ent)};
        if (b_tl != Nil) begin
          cwe = 1'b1; cwa = b_tl[EW-1:0]; cwd = {CW'(ent), c_pv, bkt};
        end
        if (ot != Nil) begin
          owe = 1'b1; owa = ot[EW-1:0]; owd = {CW'(ent), o_pv};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bucket_log2 <= 4'd8;
      count <= '0;
      free_head <= '0;
      lap <= 1'b0;
      oh <= Nil;
      ot <= Nil;
      clr <= '0;
      valid <= '0;
    end else begin
      state <= state_next;
      if (!clr[BW]) clr <= clr + 1'b1;
      if (cfg_valid && cfg_ready) bucket_log2 <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) cur <= req;
        end
        S_DECODE: begin
          bkt <= bucket_of(cur.key, bucket_log2);
          case (cur.mode) inside
            MODE_ADD: begin
              ent <= cur.handle[EW-1:0]; re <= Nil;
              rs <= (count >= CW'(Entries)) ? ST_FULL : ST_MISS;
            end
            MODE_REMOVE, MODE_NEXT: begin
              ent <= cur.handle[EW-1:0]; re <= Nil;
              rs <= hvalid ? ST_MISS : ST_BAD_HDL;
            end
            MODE_FIRST: begin
              ent <= oh[EW-1:0]; re <= oh;
              rs <= (oh != Nil) ? ST_OK : ST_MISS;
            end
            default: begin
              ent <= cur.handle[EW-1:0]; re <= Nil;
              rs <= ST_MISS;
            end
          endcase
        end
        S_FIND_RD: ent <= b_hd[EW-1:0];
        S_FIND_CMP: begin
          if (key_hit) begin
            rs <= ST_OK; re <= CW'(ent);
          end else begin
            ent <= c_nx[EW-1:0];
          end
        end
        S_RM_RD: begin
          nx <= c_nx; pv <= c_pv; bkt <= c_bk;
          onx <= o_nx; opv <= o_pv;
          if (cur.mode == MODE_NEXT) begin
            ent <= o_nx[EW-1:0];
            if (o_nx != Nil) begin rs <= ST_OK; re <= o_nx; end
          end
        end
        S_RM_OPREV: if (opv == Nil) oh <= onx;
        S_RM_ONEXT: begin
          if (onx == Nil) ot <= opv;
          valid[ent] <= 1'b0;
          count <= count - 1'b1;
          rs <= ST_OK; re <= CW'(ent);
        end
        S_ADD_RD: begin
          ent <= alloc;
          free_head <= free_head + 1'b1;
          if (free_head == '1) lap <= 1'b1;
        end
        S_ADD_LINK: begin
          if (ot == Nil) oh <= CW'(ent);
          ot <= CW'(ent);
          valid[ent] <= 1'b1;
          count <= count + 1'b1;
          rs <= ST_OK; re <= CW'(ent);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(Entries)) else $error("item count above pool size");
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    !clr[BW] |-> !req_ready) else $error("request taken during clear");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");
`endif
endmodule
`default_nettype wire
